### rtl/ptvi_pkg.sv
// shared types and constants for the periodic trilinear vector interpolator
// no dependencies
`timescale 1ns / 1ps

package ptvi_pkg;

    // default grid dimensions
    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INVERSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_LIMIT = 3'd4;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int ENTRY_IDX_W = 15;

    // one grid sample, Q16.16 per component
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    // load sideband carried alongside the coordinate mapping
    typedef struct packed {
        logic                   query;
        logic                   wr_ok;
        logic [ENTRY_IDX_W-1:0] index;
        vec_t                   data;
    } side_t;

    // one result transaction
    typedef struct packed {
        vec_t field;
        logic over;
    } res_t;

endpackage

### rtl/ptvi_axis.sv
// maps one query coordinate to wrapped corner indices and a Q0.16 weight
// depends on ptvi_pkg; six register stages
`timescale 1ns / 1ps

module ptvi_axis #(
    parameter  int GRID_N = ptvi_pkg::GRID_X_DEF,
    localparam int IDX_W  = $clog2(GRID_N)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic               in_valid,
    input  logic signed [31:0] pos,
    input  logic signed [31:0] origin,
    input  logic [31:0]        step,
    output logic               out_valid,
    output logic [IDX_W-1:0]   idx0,
    output logic [IDX_W-1:0]   idx1,
    output logic [15:0]        weight
);
    import ptvi_pkg::*;

    // residues of the byte weights and of the sign weight
    localparam longint unsigned TWO_32 = 64'h1_0000_0000;
    localparam int C1  = 256 % GRID_N;
    localparam int C2  = 65536 % GRID_N;
    localparam int C3  = (1 << 24) % GRID_N;
    localparam int CS  = int'(TWO_32 % GRID_N);
    localparam int NEG = GRID_N - CS;
    localparam logic [17:0] RECIP = 18'((1 << 18) / GRID_N);
    localparam logic [9:0]  N_L   = 10'(GRID_N);

    logic [5:0]         v_reg;
    logic signed [32:0] diff_reg;
    logic signed [49:0] ph_reg;
    logic signed [49:0] pl_reg;
    logic signed [49:0] u;
    logic signed [32:0] idx_reg;
    logic [15:0]        frac3_reg, frac4_reg, frac5_reg, frac6_reg;
    logic [17:0]        fold;
    logic [17:0]        fold4_reg, fold5_reg;
    logic [35:0]        qprod;
    logic [17:0]        q_reg;
    logic [17:0]        rem;
    logic [9:0]         rem_c;
    logic [IDX_W-1:0]   idx0_reg, idx1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    assign u     = ph_reg + (pl_reg >>> 16);
    assign fold  = 18'(idx_reg[7:0])
                 + 18'(idx_reg[15:8]) * 18'(C1)
                 + 18'(idx_reg[23:16]) * 18'(C2)
                 + 18'(idx_reg[31:24]) * 18'(C3)
                 + (idx_reg[32] ? 18'(NEG) : 18'd0);
    assign qprod = fold4_reg * RECIP;
    assign rem   = fold5_reg - q_reg * 18'(GRID_N);
    assign rem_c = (rem[9:0] >= N_L) ? rem[9:0] - N_L : rem[9:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            // offset from origin
            diff_reg  <= {pos[31], pos} - {origin[31], origin};
            // scale split in two 16 bit halves of the step
            ph_reg    <= diff_reg * $signed({1'b0, step[31:16]});
            pl_reg    <= diff_reg * $signed({1'b0, step[15:0]});
            // floor to grid units
            idx_reg   <= u[48:16];
            frac3_reg <= u[15:0];
            // fold the index into a short residue sum
            fold4_reg <= fold;
            frac4_reg <= frac3_reg;
            // quotient estimate, low by at most one
            q_reg     <= qprod[35:18];
            fold5_reg <= fold4_reg;
            frac5_reg <= frac4_reg;
            // remainder and wrapped neighbour
            idx0_reg  <= rem_c[IDX_W-1:0];
            idx1_reg  <= (rem_c == N_L - 10'd1) ? '0 : IDX_W'(rem_c + 10'd1);
            frac6_reg <= frac5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign idx0      = idx0_reg;
    assign idx1      = idx1_reg;
    assign weight    = frac6_reg;

`ifndef SYNTHESIS
    a_idx0_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (32'(idx0_reg) < GRID_N))
        else $error("corner index out of grid");
    a_idx1_next: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ((idx1_reg != idx0_reg) && (32'(idx1_reg) < GRID_N)))
        else $error("neighbour index not distinct or out of grid");
`endif

endmodule

### rtl/ptvi_grid_mem.sv
// one copy of the vector grid: one write port, two registered read ports
// depends on ptvi_pkg
`timescale 1ns / 1ps

module ptvi_grid_mem #(
    parameter  int DEPTH  = ptvi_pkg::GRID_X_DEF * ptvi_pkg::GRID_Y_DEF * ptvi_pkg::GRID_Z_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                en,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  ptvi_pkg::vec_t      wdata,
    input  logic [ADDR_W-1:0]   raddr0,
    input  logic [ADDR_W-1:0]   raddr1,
    output ptvi_pkg::vec_t      rdata0,
    output ptvi_pkg::vec_t      rdata1
);
    import ptvi_pkg::*;

    vec_t mem [DEPTH];
    vec_t rdata0_reg;
    vec_t rdata1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

### rtl/ptvi_lerp.sv
// three stage linear blend of two vectors, rounding half up
// depends on ptvi_pkg
`timescale 1ns / 1ps

module ptvi_lerp (
    input  logic           aclk,
    input  logic           ce,
    input  ptvi_pkg::vec_t p0,
    input  ptvi_pkg::vec_t p1,
    input  logic [15:0]    weight,
    output ptvi_pkg::vec_t result
);
    import ptvi_pkg::*;

    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [32:0] diff_reg [3];
    logic signed [31:0] base1_reg [3];
    logic signed [31:0] base2_reg [3];
    logic signed [49:0] prod_reg [3];
    logic signed [49:0] rounded [3];
    logic signed [31:0] res_reg [3];
    logic [15:0]        weight_reg;

    assign lo = '{p0.x, p0.y, p0.z};
    assign hi = '{p1.x, p1.y, p1.z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rounded[k] = prod_reg[k] + 50'sd32768;
        end
    end

    // p0 + floor((w * (p1 - p0) + half) / 2^16)
    always_ff @(posedge aclk) begin
        if (ce) begin
            weight_reg <= weight;
            for (int k = 0; k < 3; k++) begin
                diff_reg[k]  <= {hi[k][31], hi[k]} - {lo[k][31], lo[k]};
                base1_reg[k] <= lo[k];
                prod_reg[k]  <= diff_reg[k] * $signed({1'b0, weight_reg});
                base2_reg[k] <= base1_reg[k];
                res_reg[k]   <= base2_reg[k] + $signed(rounded[k][47:16]);
            end
        end
    end

    assign result = '{x: res_reg[0], y: res_reg[1], z: res_reg[2]};

endmodule

### rtl/periodic_trilinear_vector_interp.sv
// top level of the periodic trilinear vector interpolator
// depends on ptvi_pkg, ptvi_axis, ptvi_grid_mem, ptvi_lerp
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// cfg      in   cfg_wr_en          cfg_index, cfg_wdata
// s        in   s_valid / s_ready  s_kind, s_pos_*, s_entry_index, s_load_*
// m        out  m_valid / m_ready  m_field_*, m_over_limit
//
// one transaction a cycle unless the pipeline halts; a query result passes
// 20 pipeline stages (six for coordinate mapping, address, corner read, three
// blend levels of three, three for the magnitude test) and the output buffer.
// loads write the grid at the corner read stage, in order with queries.
// reset clears valids and configuration; the grid is undefined until loaded.
// the pipeline halts as a whole only when its two-entry output buffer is full,
// so it keeps accepting while one result waits.

module periodic_trilinear_vector_interp #(
    parameter int GRID_X = ptvi_pkg::GRID_X_DEF,
    parameter int GRID_Y = ptvi_pkg::GRID_Y_DEF,
    parameter int GRID_Z = ptvi_pkg::GRID_Z_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [ptvi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic signed [31:0]              s_pos_x,
    input  logic signed [31:0]              s_pos_y,
    input  logic signed [31:0]              s_pos_z,
    input  logic [ptvi_pkg::ENTRY_IDX_W-1:0] s_entry_index,
    input  logic signed [31:0]              s_load_x,
    input  logic signed [31:0]              s_load_y,
    input  logic signed [31:0]              s_load_z,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_field_x,
    output logic signed [31:0]              m_field_y,
    output logic signed [31:0]              m_field_z,
    output logic                            m_over_limit
);
    import ptvi_pkg::*;

    localparam int GRID_SIZE = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W    = $clog2(GRID_SIZE);
    localparam int IX_W      = $clog2(GRID_X);
    localparam int IY_W      = $clog2(GRID_Y);
    localparam int IZ_W      = $clog2(GRID_Z);
    localparam int POST_LAT  = 12;

    // configuration registers
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0]        step_inv_reg;
    logic [30:0]        mag_limit_reg;
    logic [61:0]        lim_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            step_inv_reg  <= 32'd65536;
            mag_limit_reg <= 31'h7FFF_FFFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X:        origin_x_reg  <= $signed(cfg_wdata);
                CFG_ORIGIN_Y:        origin_y_reg  <= $signed(cfg_wdata);
                CFG_ORIGIN_Z:        origin_z_reg  <= $signed(cfg_wdata);
                CFG_STEP_INVERSE:    step_inv_reg  <= cfg_wdata;
                CFG_MAGNITUDE_LIMIT: mag_limit_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // squared limit follows the register, settled long before any query needs it
    always_ff @(posedge aclk) begin
        lim_sq_reg <= mag_limit_reg * mag_limit_reg;
    end

    // pipeline advance: halts only when the output buffer is full
    logic       pipe_ce;
    logic [1:0] out_cnt_reg;
    logic       push;
    logic       pop;

    assign pipe_ce = (out_cnt_reg != 2'd2);
    assign s_ready = pipe_ce;

    logic s_accept;
    assign s_accept = s_valid && pipe_ce;

    // coordinate mapping, stages 1 to 6
    logic [IX_W-1:0] ix [2];
    logic [IY_W-1:0] iy [2];
    logic [IZ_W-1:0] iz [2];
    logic [15:0]     wx, wy, wz;
    logic            vx_valid, vy_valid, vz_valid;

    ptvi_axis #(.GRID_N(GRID_X)) u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .ce(pipe_ce), .in_valid(s_accept),
        .pos(s_pos_x), .origin(origin_x_reg), .step(step_inv_reg),
        .out_valid(vx_valid), .idx0(ix[0]), .idx1(ix[1]), .weight(wx)
    );

    ptvi_axis #(.GRID_N(GRID_Y)) u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .ce(pipe_ce), .in_valid(s_accept),
        .pos(s_pos_y), .origin(origin_y_reg), .step(step_inv_reg),
        .out_valid(vy_valid), .idx0(iy[0]), .idx1(iy[1]), .weight(wy)
    );

    ptvi_axis #(.GRID_N(GRID_Z)) u_axis_z (
        .aclk(aclk), .aresetn(aresetn), .ce(pipe_ce), .in_valid(s_accept),
        .pos(s_pos_z), .origin(origin_z_reg), .step(step_inv_reg),
        .out_valid(vz_valid), .idx0(iz[0]), .idx1(iz[1]), .weight(wz)
    );

    // load sideband travels beside the mapping; index 6 is the address stage
    side_t side_in;
    side_t side_reg [7];

    assign side_in = '{
        query: (s_kind == KIND_QUERY),
        wr_ok: ({17'd0, s_entry_index} < 32'(GRID_SIZE)),
        index: s_entry_index,
        data:  '{x: s_load_x, y: s_load_y, z: s_load_z}
    };

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < 7; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // stage 7: corner addresses; copy kx*2+ky reads the two z corners
    logic [ADDR_W-1:0] addr_next [4][2];
    logic [ADDR_W-1:0] addr_reg  [4][2];
    logic              v7_reg;
    logic [15:0]       wx7_reg, wy7_reg, wz7_reg;

    always_comb begin
        for (int kx = 0; kx < 2; kx++) begin
            for (int ky = 0; ky < 2; ky++) begin
                for (int kz = 0; kz < 2; kz++) begin
                    addr_next[kx*2+ky][kz] = ADDR_W'(ix[kx]) * ADDR_W'(GRID_Y * GRID_Z)
                                           + ADDR_W'(iy[ky]) * ADDR_W'(GRID_Z)
                                           + ADDR_W'(iz[kz]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            addr_reg <= addr_next;
            wx7_reg  <= wx;
            wy7_reg  <= wy;
            wz7_reg  <= wz;
        end
    end

    // stage 8: grid read for queries, grid write for loads
    logic              v8_reg;
    logic [15:0]       wx8_reg, wy8_reg, wz8_reg;
    logic              mem_we;
    logic [ADDR_W+14:0] widx;
    logic [ADDR_W-1:0] waddr;
    vec_t              corner0 [4];
    vec_t              corner1 [4];

    assign mem_we = v7_reg && !side_reg[6].query && side_reg[6].wr_ok;
    assign widx   = {{ADDR_W{1'b0}}, side_reg[6].index};
    assign waddr  = widx[ADDR_W-1:0];

    for (genvar k = 0; k < 4; k++) begin : g_mem
        ptvi_grid_mem #(.DEPTH(GRID_SIZE)) u_mem (
            .aclk(aclk), .en(pipe_ce), .we(mem_we), .waddr(waddr),
            .wdata(side_reg[6].data),
            .raddr0(addr_reg[k][0]), .raddr1(addr_reg[k][1]),
            .rdata0(corner0[k]), .rdata1(corner1[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            wx8_reg <= wx7_reg;
            wy8_reg <= wy7_reg;
            wz8_reg <= wz7_reg;
        end
    end

    // weights wait for their blend level
    logic [15:0] wy_dly_reg [3];
    logic [15:0] wx_dly_reg [6];

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            wy_dly_reg[0] <= wy8_reg;
            for (int k = 1; k < 3; k++) begin
                wy_dly_reg[k] <= wy_dly_reg[k-1];
            end
            wx_dly_reg[0] <= wx8_reg;
            for (int k = 1; k < 6; k++) begin
                wx_dly_reg[k] <= wx_dly_reg[k-1];
            end
        end
    end

    // blends along z, then y, then x
    vec_t zbl [4];
    vec_t ybl [2];
    vec_t xbl;

    for (genvar k = 0; k < 4; k++) begin : g_lerp_z
        ptvi_lerp u_lerp (
            .aclk(aclk), .ce(pipe_ce), .p0(corner0[k]), .p1(corner1[k]),
            .weight(wz8_reg), .result(zbl[k])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_lerp_y
        ptvi_lerp u_lerp (
            .aclk(aclk), .ce(pipe_ce), .p0(zbl[k*2]), .p1(zbl[k*2+1]),
            .weight(wy_dly_reg[2]), .result(ybl[k])
        );
    end

    ptvi_lerp u_lerp_x (
        .aclk(aclk), .ce(pipe_ce), .p0(ybl[0]), .p1(ybl[1]),
        .weight(wx_dly_reg[5]), .result(xbl)
    );

    // magnitude test: squares, partial sum, full sum
    logic signed [63:0] sq_x, sq_y, sq_z;
    logic [63:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic [63:0]        sxy_reg, sz_reg, tot_reg;
    vec_t               fa_reg, fb_reg, fc_reg;

    assign sq_x = xbl.x * xbl.x;
    assign sq_y = xbl.y * xbl.y;
    assign sq_z = xbl.z * xbl.z;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            sq_x_reg <= sq_x;
            sq_y_reg <= sq_y;
            sq_z_reg <= sq_z;
            fa_reg   <= xbl;
            sxy_reg  <= sq_x_reg + sq_y_reg;
            sz_reg   <= sq_z_reg;
            fb_reg   <= fa_reg;
            tot_reg  <= sxy_reg + sz_reg;
            fc_reg   <= fb_reg;
        end
    end

    // valid bits; loads drop out after the write stage
    logic [POST_LAT-1:0] post_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg     <= 1'b0;
            v8_reg     <= 1'b0;
            post_v_reg <= '0;
        end else if (pipe_ce) begin
            v7_reg     <= vx_valid;
            v8_reg     <= v7_reg && side_reg[6].query;
            post_v_reg <= {post_v_reg[POST_LAT-2:0], v8_reg};
        end
    end

    // two-entry output buffer
    res_t       push_data;
    res_t       out_buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;

    assign push      = pipe_ce && post_v_reg[POST_LAT-1];
    assign pop       = m_valid && m_ready;
    assign push_data = '{field: fc_reg, over: (tot_reg > {2'b00, lim_sq_reg})};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            out_cnt_reg <= out_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid      = (out_cnt_reg != 2'd0);
    assign m_field_x    = out_buf_reg[rd_ptr_reg].field.x;
    assign m_field_y    = out_buf_reg[rd_ptr_reg].field.y;
    assign m_field_z    = out_buf_reg[rd_ptr_reg].field.z;
    assign m_over_limit = out_buf_reg[rd_ptr_reg].over;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= 2'd2)
        else $error("output buffer overflow");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg == $past(out_cnt_reg) + 2'($past(push)) - 2'($past(pop)))
        else $error("output buffer count lost a transaction");
    a_axes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (vx_valid == vy_valid) && (vy_valid == vz_valid))
        else $error("axis mapping pipelines out of step");
`endif

endmodule

### sim/ptvi_checker.sv
// result checker for the periodic trilinear vector interpolator
// tracks grid contents and register values from the observed channels, predicts each
// query result and compares it with the result stream; depends on ptvi_pkg
`timescale 1ns / 1ps

module ptvi_checker #(
    parameter int GRID_X = ptvi_pkg::GRID_X_DEF,
    parameter int GRID_Y = ptvi_pkg::GRID_Y_DEF,
    parameter int GRID_Z = ptvi_pkg::GRID_Z_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ptvi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_kind,
    input  logic signed [31:0]               s_pos_x,
    input  logic signed [31:0]               s_pos_y,
    input  logic signed [31:0]               s_pos_z,
    input  logic [ptvi_pkg::ENTRY_IDX_W-1:0] s_entry_index,
    input  logic signed [31:0]               s_load_x,
    input  logic signed [31:0]               s_load_y,
    input  logic signed [31:0]               s_load_z,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic signed [31:0]               m_field_x,
    input  logic signed [31:0]               m_field_y,
    input  logic signed [31:0]               m_field_z,
    input  logic                             m_over_limit,
    output int                               mismatches,
    output int                               outstanding,
    output int                               results_seen,
    output int                               over_seen
);
    import ptvi_pkg::*;

    localparam int GRID_N = GRID_X * GRID_Y * GRID_Z;

    vec_t               grid_model [GRID_N];
    logic signed [31:0] org_x, org_y, org_z;
    logic [31:0]        step_inv;
    logic [30:0]        mag_limit;
    res_t               awaited [$];

    // wrapped corner indices and q0.16 weight for one axis
    task automatic map_axis(input logic signed [31:0] pos, input logic signed [31:0] org,
                            input int n, output int i0, output int i1, output longint w);
        longint diff, u, cell_idx, r;
        longint unsigned mag, hi, lo;
        diff = longint'(pos) - longint'(org);
        mag  = (diff < 0) ? longint'(-diff) : diff;
        hi   = mag * longint'(step_inv >> 16);
        lo   = mag * longint'(step_inv & 32'hFFFF);
        if (diff >= 0)
            u = hi + (lo >> 16);
        else
            u = -longint'(hi + ((lo + 65535) >> 16));
        w        = u & 64'hFFFF;
        cell_idx = (u - w) / 65536;
        r        = cell_idx % n;
        if (r < 0)
            r += n;
        i0 = int'(r);
        i1 = (r + 1 == n) ? 0 : int'(r + 1);
    endtask

    // rounds half up
    function automatic longint lerp16(longint p0, longint p1, longint w1);
        longint w0;
        w0 = 65536 - w1;
        return (w0 * p0 + w1 * p1 + 32768) >>> 16;
    endfunction

    function automatic longint comp_of(int idx, int c);
        case (c)
            0:       return longint'(grid_model[idx].x);
            1:       return longint'(grid_model[idx].y);
            default: return longint'(grid_model[idx].z);
        endcase
    endfunction

    task automatic predict_query(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz);
        int xs [2], ys [2], zs [2];
        longint wa, wb, wc, base;
        longint along_z [2], along_y [2], f [3];
        longint unsigned sq, lim;
        res_t r;
        map_axis(px, org_x, GRID_X, xs[0], xs[1], wa);
        map_axis(py, org_y, GRID_Y, ys[0], ys[1], wb);
        map_axis(pz, org_z, GRID_Z, zs[0], zs[1], wc);
        for (int c = 0; c < 3; c++) begin
            for (int kx = 0; kx < 2; kx++) begin
                for (int ky = 0; ky < 2; ky++) begin
                    base = longint'(xs[kx]) * GRID_Y * GRID_Z + longint'(ys[ky]) * GRID_Z;
                    along_z[ky] = lerp16(comp_of(int'(base) + zs[0], c),
                                         comp_of(int'(base) + zs[1], c), wc);
                end
                along_y[kx] = lerp16(along_z[0], along_z[1], wb);
            end
            f[c] = lerp16(along_y[0], along_y[1], wa);
        end
        // squares summed unsigned, the total can pass 2^63
        sq  = longint'(f[0] * f[0]) + longint'(f[1] * f[1]) + longint'(f[2] * f[2]);
        lim = longint'(mag_limit) * longint'(mag_limit);
        r.field.x = f[0][31:0];
        r.field.y = f[1][31:0];
        r.field.z = f[2][31:0];
        r.over    = (sq > lim);
        awaited.push_back(r);
    endtask

    always @(posedge aclk) begin
        res_t e;
        if (!aresetn) begin
            org_x        = '0;
            org_y        = '0;
            org_z        = '0;
            step_inv     = 32'd65536;
            mag_limit    = '1;
            mismatches   = 0;
            results_seen = 0;
            over_seen    = 0;
            awaited.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ORIGIN_X:        org_x     = cfg_wdata;
                    CFG_ORIGIN_Y:        org_y     = cfg_wdata;
                    CFG_ORIGIN_Z:        org_z     = cfg_wdata;
                    CFG_STEP_INVERSE:    step_inv  = cfg_wdata;
                    CFG_MAGNITUDE_LIMIT: mag_limit = cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_over_limit)
                    over_seen++;
                if (awaited.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result %h %h %h %b", $time,
                             m_field_x, m_field_y, m_field_z, m_over_limit);
                end else begin
                    e = awaited.pop_front();
                    if (m_field_x !== e.field.x) begin
                        mismatches++;
                        $display("%0t: field_x expected %h got %h", $time, e.field.x, m_field_x);
                    end
                    if (m_field_y !== e.field.y) begin
                        mismatches++;
                        $display("%0t: field_y expected %h got %h", $time, e.field.y, m_field_y);
                    end
                    if (m_field_z !== e.field.z) begin
                        mismatches++;
                        $display("%0t: field_z expected %h got %h", $time, e.field.z, m_field_z);
                    end
                    if (m_over_limit !== e.over) begin
                        mismatches++;
                        $display("%0t: over_limit expected %b got %b", $time, e.over,
                                 m_over_limit);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_LOAD) begin
                    if (int'(s_entry_index) < GRID_N)
                        grid_model[s_entry_index] = '{x: s_load_x, y: s_load_y, z: s_load_z};
                end else begin
                    predict_query(s_pos_x, s_pos_y, s_pos_z);
                end
            end
        end
        outstanding = awaited.size();
    end

endmodule

### sim/periodic_trilinear_vector_interp_tb.sv
// top of the periodic trilinear vector interpolator testbench
// drives stimulus and configuration, gives the verdict; depends on ptvi_pkg,
// ptvi_checker and the block itself
`timescale 1ns / 1ps

module periodic_trilinear_vector_interp_tb;
    import ptvi_pkg::*;

    localparam int GRID_N      = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;    // pipeline depth plus margin
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 230;
    localparam int NEAR        = 4;     // loaded cells on each side of index zero, per axis

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_wdata;
    logic                   s_valid, s_ready, s_kind;
    logic signed [31:0]     s_pos_x, s_pos_y, s_pos_z;
    logic [ENTRY_IDX_W-1:0] s_entry_index;
    logic signed [31:0]     s_load_x, s_load_y, s_load_z;
    logic                   m_valid, m_ready;
    logic signed [31:0]     m_field_x, m_field_y, m_field_z;
    logic                   m_over_limit;

    int mismatches, outstanding, results_seen, over_seen;
    int cycles = 0;
    int loads_sent, queries_sent, settings_used;

    // shared between sender and receiver processes
    bit quiet;      // no idling on either side
    bit hold_req;   // asks receiver for a long hold-off

    // current origin and step, so queries land in the loaded block
    logic signed [31:0] cur_org [3];
    logic [31:0]        cur_step;

    periodic_trilinear_vector_interp i_dut (.*);

    ptvi_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 30);
            end
        end
    end

    // one input transaction, with an occasional idle gap in front
    task automatic send(input logic kind, input logic signed [31:0] px,
                        input logic signed [31:0] py, input logic signed [31:0] pz,
                        input logic [ENTRY_IDX_W-1:0] idx, input logic signed [31:0] lx,
                        input logic signed [31:0] ly, input logic signed [31:0] lz);
        if (!quiet && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_pos_x       <= px;
        s_pos_y       <= py;
        s_pos_z       <= pz;
        s_entry_index <= idx;
        s_load_x      <= lx;
        s_load_y      <= ly;
        s_load_z      <= lz;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_LOAD)
            loads_sent++;
        else
            queries_sent++;
    endtask

    task automatic load(input int idx, input logic signed [31:0] lx,
                        input logic signed [31:0] ly, input logic signed [31:0] lz);
        send(KIND_LOAD, $urandom, $urandom, $urandom, ENTRY_IDX_W'(idx), lx, ly, lz);
    endtask

    task automatic query(input logic signed [31:0] px, input logic signed [31:0] py,
                         input logic signed [31:0] pz);
        send(KIND_QUERY, px, py, pz, ENTRY_IDX_W'($urandom), $urandom, $urandom, $urandom);
    endtask

    // sender pause: nothing left in flight, loads included
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // writes every register back to back, block idle
    task automatic apply_cfg(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] step,
                             input logic [31:0] lim);
        logic [31:0] vals [5];
        logic [CFG_IDX_W-1:0] regs [5];
        vals = '{ox, oy, oz, step, lim};
        regs = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z, CFG_STEP_INVERSE,
                 CFG_MAGNITUDE_LIMIT};
        for (int k = 0; k < 5; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cur_org  = '{ox, oy, oz};
        cur_step = step;
        settings_used++;
        @(posedge aclk);
    endtask

    // sample values: full range, small, extremes or moderate
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'h1FFFFF) - 32'h100000;
            2:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(32'h0FFFFFFF) - 32'h08000000;
        endcase
    endfunction

    // positions within two cells of the origin, so every corner is a loaded entry;
    // clamping to the 32 bit range only moves a position towards the origin
    function automatic logic [31:0] rand_pos(int axis);
        longint unsigned rnd;
        longint span, p;
        span = (cur_step == 32'd0) ? (longint'(1) << 33)
                                   : (longint'(1) << 33) / longint'(cur_step);
        rnd  = {$urandom, $urandom};
        p    = longint'(cur_org[axis]) + longint'(rnd % longint'(2 * span + 1)) - span;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[31:0];
    endfunction

    function automatic logic [31:0] rand_step();
        case ($urandom_range(6))
            0:       return 32'd1;
            1:       return 32'hFFFFFFFF;
            2:       return 32'd65536;
            3:       return 32'd0;          // every position folds onto entry zero
            4:       return $urandom_range(32'h40000, 32'h4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'hFFFFFFFF;   // top bit is dropped by the block
            2:       return $urandom_range(32'h200000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        loads_sent    = 0;
        queries_sent  = 0;
        settings_used = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        cur_org       = '{default: '0};
        cur_step      = 32'd65536;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_ORIGIN_X;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_kind        <= KIND_LOAD;
        s_pos_x       <= '0;
        s_pos_y       <= '0;
        s_pos_z       <= '0;
        s_entry_index <= '0;
        s_load_x      <= '0;
        s_load_y      <= '0;
        s_load_z      <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // load every cell within four of index zero on each axis, wrapping below
        // zero; all queries land in this block, so none reads an unloaded entry
        for (int gx = -NEAR; gx < NEAR; gx++)
            for (int gy = -NEAR; gy < NEAR; gy++)
                for (int gz = -NEAR; gz < NEAR; gz++)
                    load(((gx + GRID_X_DEF) % GRID_X_DEF) * GRID_Y_DEF * GRID_Z_DEF
                         + ((gy + GRID_Y_DEF) % GRID_Y_DEF) * GRID_Z_DEF
                         + (gz + GRID_Z_DEF) % GRID_Z_DEF,
                         rand_sample(), rand_sample(), rand_sample());

        // directed: extreme samples at both ends of the grid, reset settings
        load(0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        load(GRID_N - 1, 32'h80000000, 32'h7FFFFFFF, 32'h1);
        query(0, 0, 0);                                      // exact grid point
        query(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000);     // negative wraps to the top
        query(32'hFFFF8000, 32'h00008000, 32'hFFFFFFFF);     // halfway weights on x and y
        query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        query(32'h80000000, 32'h80000000, 32'h80000000);
        query(32'h001F8000, 32'h001FC000, 32'h001F0001);     // wrap between last and first
        drain();

        // origin extremes, largest step, zero limit
        apply_cfg(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0);
        query(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        query(32'h80000000, 32'h7FFFFFFF, 32'h0);
        query(32'h80000001, 32'h7FFFFFFE, 32'h80000002);     // a cell either side of origin
        drain();

        // zero step folds every position onto entry zero
        apply_cfg(32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 32'h7FFFFFFF);
        query(32'h80000000, 32'h7FFFFFFF, 32'h1);
        query(32'h0, 32'hDEADBEEF, 32'h7FFFFFFF);
        drain();

        // smallest step, limit with its top bit set
        apply_cfg(32'h0, 32'h10000, 32'hFFFF0000, 32'h1, 32'hFFFFFFFF);
        query(32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        query(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        drain();

        // random phases, each under its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            apply_cfg($urandom_range(1) ? 32'h0 : $urandom, $urandom_range(1) ? 32'h0 : $urandom,
                      $urandom_range(1) ? 32'h0 : $urandom, rand_step(), rand_limit());
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mid-phase the receiver stops while items keep arriving
                if (ph == 1 && n == PHASE_ITEMS / 3)
                    hold_req = 1'b1;
                if ($urandom_range(99) < 30)
                    load($urandom_range(GRID_N - 1), rand_sample(), rand_sample(),
                         rand_sample());
                else
                    query(rand_pos(0), rand_pos(1), rand_pos(2));
            end
            quiet = 1'b0;
            drain();
        end

        $display("covered %0d loads and %0d queries under %0d register settings",
                 loads_sent, queries_sent, settings_used + 1);
        $display("%0d results checked, %0d flagged over the limit", results_seen, over_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
